[src/ssnap_pkg.sv]
// ----------------------------------------------------------------------------
// ssnap_pkg
// Shared widths, register indexes, region codes and the side-band word that
// travels next to the divider lanes.
// ----------------------------------------------------------------------------
package ssnap_pkg;

    localparam int CW   = 32;  // coordinate width
    localparam int DW   = 33;  // coordinate difference width
    localparam int PW   = 66;  // square / squared length width
    localparam int NW   = 98;  // dividend width
    localparam int QW   = 32;  // quotient width
    localparam int RW   = 31;  // radius width
    localparam int IW   = 3;   // register index width

    localparam logic [IW-1:0] REG_END_A_X     = 3'd0;
    localparam logic [IW-1:0] REG_END_A_Y     = 3'd1;
    localparam logic [IW-1:0] REG_END_A_Z     = 3'd2;
    localparam logic [IW-1:0] REG_END_B_X     = 3'd3;
    localparam logic [IW-1:0] REG_END_B_Y     = 3'd4;
    localparam logic [IW-1:0] REG_END_B_Z     = 3'd5;
    localparam logic [IW-1:0] REG_SNAP_RADIUS = 3'd6;

    localparam logic [1:0] REGION_BEFORE = 2'd0;
    localparam logic [1:0] REGION_ALONG  = 2'd1;
    localparam logic [1:0] REGION_PAST   = 2'd2;

    typedef struct packed {
        logic              degen;
        logic [1:0]        region;
        logic [2:0][DW-1:0] v;
        logic [PW-1:0]     dist_end;
    } t_side;

endpackage

[src/ssnap_div.sv]
// ----------------------------------------------------------------------------
// ssnap_div
// Pipelined restoring divider, one quotient bit per stage. The dividend's
// upper part must already be below the divisor, so the quotient fits QW bits.
// ----------------------------------------------------------------------------
module ssnap_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ssnap_pkg::NW-1:0]   i_num,
    input  logic [ssnap_pkg::PW-1:0]   i_den,
    output logic [ssnap_pkg::QW-1:0]   o_quo
);

    localparam int QW = ssnap_pkg::QW;
    localparam int PW = ssnap_pkg::PW;

    logic [PW-1:0] r_rem [1:QW];
    logic [QW-1:0] r_low [1:QW];
    logic [QW-1:0] r_q   [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [PW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [PW:0]   t;
        logic [PW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = i_num[ssnap_pkg::NW-1:QW];
            assign low_in = i_num[QW-1:0];
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k];
            assign low_in = r_low[k];
            assign q_in   = r_q[k];
        end

        assign t    = {rem_in, low_in[QW-1]};
        assign ge   = t >= {1'b0, i_den};
        assign diff = t - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? diff[PW-1:0] : t[PW-1:0];
                r_low[k+1] <= {low_in[QW-2:0], 1'b0};
                r_q[k+1]   <= {q_in[QW-2:0], ge};
            end
        end
    end

    assign o_quo = r_q[QW];

endmodule

[src/segment_snap_3d_unit.sv]
// ----------------------------------------------------------------------------
// segment_snap_3d_unit
// Snaps a Q16.16 query point to the configured segment a-b.
// ----------------------------------------------------------------------------
// One word per cycle in and out; the pipe is the 32-stage divider lanes (one
// quotient bit each) plus five stages ahead for the differences, products, dot
// sums, region with dividend partial products and dividend, and three behind
// for the projected point, its distance and the output register. The whole pipe
// advances together whenever the output register is empty or being taken.
// After a register write, the squared length passes r_dd and then r_len2, and
// the radius square r_r2 is registered straight from r_rad.
module segment_snap_3d_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,   // query_x, query_y, query_z
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,   // out_x, out_y, out_z
    output logic [2:0]   o_m_axis_tuser    // snapped, region
);

    localparam int CW = ssnap_pkg::CW;
    localparam int DW = ssnap_pkg::DW;
    localparam int PW = ssnap_pkg::PW;
    localparam int NW = ssnap_pkg::NW;
    localparam int QW = ssnap_pkg::QW;
    localparam int RW = ssnap_pkg::RW;

    // configuration
    logic signed [CW-1:0] r_a [3];
    logic signed [CW-1:0] r_b [3];
    logic [RW-1:0]        r_rad;
    logic [PW-1:0]        r_dd [3];
    logic [PW-1:0]        r_len2;
    logic [2*RW-1:0]      r_r2;

    logic signed [DW-1:0] d     [3];
    logic [CW-1:0]        d_abs [3];
    logic signed [CW-1:0] q     [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= '0;
                r_b[i] <= '0;
            end
            r_rad <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssnap_pkg::REG_END_A_X:     r_a[0] <= i_cfg_wdata;
                ssnap_pkg::REG_END_A_Y:     r_a[1] <= i_cfg_wdata;
                ssnap_pkg::REG_END_A_Z:     r_a[2] <= i_cfg_wdata;
                ssnap_pkg::REG_END_B_X:     r_b[0] <= i_cfg_wdata;
                ssnap_pkg::REG_END_B_Y:     r_b[1] <= i_cfg_wdata;
                ssnap_pkg::REG_END_B_Z:     r_b[2] <= i_cfg_wdata;
                ssnap_pkg::REG_SNAP_RADIUS: r_rad  <= i_cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i]     = DW'(r_b[i]) - DW'(r_a[i]);
            d_abs[i] = d[i][DW-1] ? CW'(-d[i]) : CW'(d[i]);
            q[i]     = signed'(i_s_axis_tdata[CW*i +: CW]);
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [2*DW-1:0] sq;
        for (int i = 0; i < 3; i++) begin
            sq       = (2*DW)'(d[i]) * (2*DW)'(d[i]);
            r_dd[i] <= sq[PW-1:0];
        end
        r_len2 <= r_dd[0] + r_dd[1] + r_dd[2];
        r_r2   <= (2*RW)'(r_rad) * (2*RW)'(r_rad);
    end

    // pipeline control
    logic en;
    logic r_ov;
    assign en              = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 1: differences to both ends
    logic                 r1_vld;
    logic signed [DW-1:0] r1_v [3];
    logic signed [DW-1:0] r1_w [3];
    // stage 2: products
    logic                   r2_vld;
    logic signed [2*DW-1:0] r2_vd [3];
    logic [PW-1:0]          r2_va [3];
    logic [PW-1:0]          r2_vb [3];
    logic signed [DW-1:0]   r2_v  [3];
    // stage 3: sums
    logic                 r3_vld;
    logic signed [PW:0]   r3_dot;
    logic [PW-1:0]        r3_dista;
    logic [PW-1:0]        r3_distb;
    logic signed [DW-1:0] r3_v [3];
    // stage 4: region and dividend partial products
    logic                 r4_vld;
    ssnap_pkg::t_side     r4_side;
    logic [DW+CW-1:0]     r4_plo [3];
    logic [DW+CW-1:0]     r4_phi [3];
    // stage 5: dividend
    logic                 r5_vld;
    ssnap_pkg::t_side     r5_side;
    logic [NW-1:0]        r5_num [3];

    always_ff @(posedge i_clk) begin
        logic signed [2*DW-1:0] pa;
        logic signed [2*DW-1:0] pb;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i]  <= DW'(q[i]) - DW'(r_a[i]);
                r1_w[i]  <= DW'(q[i]) - DW'(r_b[i]);
                r2_vd[i] <= (2*DW)'(r1_v[i]) * (2*DW)'(d[i]);
                pa        = (2*DW)'(r1_v[i]) * (2*DW)'(r1_v[i]);
                pb        = (2*DW)'(r1_w[i]) * (2*DW)'(r1_w[i]);
                r2_va[i] <= pa[PW-1:0];
                r2_vb[i] <= pb[PW-1:0];
                r2_v[i]  <= r1_v[i];
                r3_v[i]  <= r2_v[i];
            end
            r3_dot   <= (PW+1)'(r2_vd[0]) + (PW+1)'(r2_vd[1]) + (PW+1)'(r2_vd[2]);
            r3_dista <= r2_va[0] + r2_va[1] + r2_va[2];
            r3_distb <= r2_vb[0] + r2_vb[1] + r2_vb[2];
        end
    end

    logic [1:0]    s4_region;
    logic [PW-1:0] dotu;
    assign dotu = r3_dot[PW-1:0];

    always_comb begin
        if (r3_dot[PW])
            s4_region = ssnap_pkg::REGION_BEFORE;
        else if (dotu > r_len2)
            s4_region = ssnap_pkg::REGION_PAST;
        else
            s4_region = ssnap_pkg::REGION_ALONG;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side.degen    <= (r_len2 == '0);
            r4_side.region   <= s4_region;
            r4_side.dist_end <= (s4_region == ssnap_pkg::REGION_BEFORE) ? r3_dista : r3_distb;
            for (int i = 0; i < 3; i++) begin
                r4_side.v[i] <= r3_v[i];
                r4_plo[i]    <= (DW+CW)'(dotu[DW-1:0]) * (DW+CW)'(d_abs[i]);
                r4_phi[i]    <= (DW+CW)'(dotu[PW-1:DW]) * (DW+CW)'(d_abs[i]);
                r5_num[i]    <= (NW'(r4_phi[i]) << DW) + NW'(r4_plo[i]);
            end
            r5_side <= r4_side;
        end
    end

    // divider lanes and side band
    logic [QW-1:0]    quo [3];
    logic             r_dv [0:QW-1];
    ssnap_pkg::t_side r_sd [0:QW-1];

    for (genvar i = 0; i < 3; i++) begin : g_div
        ssnap_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r5_num[i]),
            .i_den (r_len2),
            .o_quo (quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r5_side;
            for (int k = 1; k < QW; k++)
                r_sd[k] <= r_sd[k-1];
        end
    end

    // stage 6: projected point, stage 7: squares, stage 8: output
    logic                 r6_vld;
    ssnap_pkg::t_side     r6_side;
    logic signed [CW-1:0] r6_pp   [3];
    logic signed [DW:0]   r6_diff [3];
    logic                 r7_vld;
    ssnap_pkg::t_side     r7_side;
    logic signed [CW-1:0] r7_pp   [3];
    logic [PW-1:0]        r7_sq   [3];

    logic signed [DW:0] s_off [3];
    logic signed [DW:0] s_pp  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s_off[i] = d[i][DW-1] ? -signed'((DW+1)'(quo[i])) : signed'((DW+1)'(quo[i]));
            s_pp[i]  = (DW+1)'(r_a[i]) + s_off[i];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [2*DW+1:0] sq;
        if (en) begin
            r6_side <= r_sd[QW-1];
            r7_side <= r6_side;
            for (int i = 0; i < 3; i++) begin
                r6_pp[i]   <= s_pp[i][CW-1:0];
                r6_diff[i] <= (DW+1)'(signed'(r_sd[QW-1].v[i])) - s_off[i];
                sq          = (2*DW+2)'(r6_diff[i]) * (2*DW+2)'(r6_diff[i]);
                r7_sq[i]   <= sq[PW-1:0];
                r7_pp[i]   <= r6_pp[i];
            end
        end
    end

    logic [PW-1:0]   s8_dist;
    logic            s8_snap;
    logic [CW-1:0]   s8_c [3];

    always_comb begin
        s8_dist = (r7_side.region == ssnap_pkg::REGION_ALONG)
                ? r7_sq[0] + r7_sq[1] + r7_sq[2] : r7_side.dist_end;
        s8_snap = !r7_side.degen && (s8_dist < PW'(r_r2));
        for (int i = 0; i < 3; i++) begin
            case (r7_side.region)
                ssnap_pkg::REGION_BEFORE: s8_c[i] = r_a[i];
                ssnap_pkg::REGION_PAST:   s8_c[i] = r_b[i];
                default:                  s8_c[i] = r7_pp[i];
            endcase
            if (!s8_snap)
                s8_c[i] = '0;
        end
    end

    logic          r_osnap;
    logic [1:0]    r_oregion;
    logic [CW-1:0] r_oc [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_osnap   <= s8_snap;
            r_oregion <= r7_side.region;
            for (int i = 0; i < 3; i++)
                r_oc[i] <= s8_c[i];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            for (int k = 0; k < QW; k++)
                r_dv[k] <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r1_vld  <= i_s_axis_tvalid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_vld  <= r3_vld;
            r5_vld  <= r4_vld;
            r_dv[0] <= r5_vld;
            for (int k = 1; k < QW; k++)
                r_dv[k] <= r_dv[k-1];
            r6_vld  <= r_dv[QW-1];
            r7_vld  <= r6_vld;
            r_ov    <= r7_vld;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_oc[2], r_oc[1], r_oc[0]};
    assign o_m_axis_tuser  = {r_oregion, r_osnap};

    a_nosnap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !r_osnap) |-> (o_m_axis_tdata == '0))
        else $error("unsnapped word carries coordinates");

    a_before_is_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_osnap && r_oregion == ssnap_pkg::REGION_BEFORE)
        |-> (r_oc[0] == r_a[0] && r_oc[1] == r_a[1] && r_oc[2] == r_a[2]))
        else $error("region before snapped off end a");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// segment_snap_3d_unit testbench
// Drives query points through the stream port under several segment and
// radius settings, predicts region, snap flag and snapped point in wide
// integer arithmetic, and checks every output word in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 60;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic        snapped;
        logic [1:0]  region;
        logic [31:0] x, y, z;
    } t_snap;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_wdata = '0;
    logic         i_s_axis_tvalid = 0;
    logic         o_s_axis_tready;
    logic [95:0]  i_s_axis_tdata = '0;  // query_x, query_y, query_z
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 0;
    logic [95:0]  o_m_axis_tdata;       // out_x, out_y, out_z
    logic [2:0]   o_m_axis_tuser;       // snapped, region

    segment_snap_3d_unit i_dut (.*);

    initial forever #5 i_clk = ~i_clk;

    logic signed [31:0] seg_a [3];
    logic signed [31:0] seg_b [3];
    logic [30:0]        radius;
    t_snap              pending [$];
    int                 mismatch_cnt = 0;
    longint             cyc = 0;
    bit                 hold_off = 0;
    bit                 rx_busy = 1;

    function automatic t_snap snap_point(logic signed [31:0] q [3]);
        logic signed [33:0]  d [3], v [3];
        logic signed [31:0]  pp [3], cand [3];
        logic signed [69:0]  dot, len2;
        logic signed [35:0]  off;
        logic [69:0]         sum_sq, r2;
        logic signed [34:0]  e;
        t_snap               r;
        dot = 0;
        len2 = 0;
        sum_sq = 0;
        r = '0;
        r.region = ssnap_pkg::REGION_ALONG;
        for (int i = 0; i < 3; i++) begin
            d[i] = 34'(seg_b[i]) - 34'(seg_a[i]);
            v[i] = 34'(q[i]) - 34'(seg_a[i]);
            dot += 70'(v[i]) * 70'(d[i]);
            len2 += 70'(d[i]) * 70'(d[i]);
        end
        if (len2 == 0) return r;
        if (dot < 0) begin
            r.region = ssnap_pkg::REGION_BEFORE;
            cand = seg_a;
        end else if (dot > len2) begin
            r.region = ssnap_pkg::REGION_PAST;
            cand = seg_b;
        end else begin
            for (int i = 0; i < 3; i++) begin
                // dot*d fits: dot<=len2<2^68, |d|<2^33 -> use 104-bit math
                off = 36'(($signed(104'(dot)) * $signed(104'(d[i]))) / $signed(104'(len2)));
                pp[i] = 32'(36'(seg_a[i]) + off);
            end
            cand = pp;
        end
        for (int i = 0; i < 3; i++) begin
            e = 35'(q[i]) - 35'(cand[i]);
            sum_sq += 70'(e) * 70'(e);
        end
        r2 = 70'(radius) * 70'(radius);
        if (sum_sq < r2) begin
            r.snapped = 1;
            r.x = cand[0];
            r.y = cand[1];
            r.z = cand[2];
        end
        return r;
    endfunction

    // receiver: stall pattern plus optional long hold-off
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > 2000000) begin
            $display("TEST FAILED");
            $finish;
        end
        i_m_axis_tready <= !hold_off && (rx_busy ? ($urandom_range(0, 3) != 0) : 1'b1);
        if (o_m_axis_tvalid && i_m_axis_tready && i_rst_n) begin
            t_snap got, want;
            got = {o_m_axis_tuser[0], o_m_axis_tuser[2:1],
                   o_m_axis_tdata[31:0], o_m_axis_tdata[63:32], o_m_axis_tdata[95:64]};
            if (pending.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected word %h", got);
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("mismatch: exp snap=%0d reg=%0d %h %h %h",
                                 want.snapped, want.region, want.x, want.y, want.z);
                        $display("          got snap=%0d reg=%0d %h %h %h",
                                 got.snapped, got.region, got.x, got.y, got.z);
                    end
                end
            end
        end
    end

    initial forever begin
        repeat ($urandom_range(50, 400)) @(posedge i_clk);
        rx_busy = !rx_busy;
    end

    task automatic send_query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        logic signed [31:0] q [3];
        q[0] = x; q[1] = y; q[2] = z;
        i_s_axis_tvalid <= 1;
        i_s_axis_tdata <= {z, y, x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending.insert(pending.size(), snap_point(q));
        if ($urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            ssnap_pkg::REG_END_A_X, ssnap_pkg::REG_END_A_Y, ssnap_pkg::REG_END_A_Z:
                seg_a[idx] = val;
            ssnap_pkg::REG_END_B_X, ssnap_pkg::REG_END_B_Y, ssnap_pkg::REG_END_B_Z:
                seg_b[idx - 3] = val;
            ssnap_pkg::REG_SNAP_RADIUS: radius = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_segment(logic [31:0] ax, ay, az, bx, by, bz, logic [31:0] r);
        write_reg(ssnap_pkg::REG_END_A_X, ax);
        write_reg(ssnap_pkg::REG_END_A_Y, ay);
        write_reg(ssnap_pkg::REG_END_A_Z, az);
        write_reg(ssnap_pkg::REG_END_B_X, bx);
        write_reg(ssnap_pkg::REG_END_B_Y, by);
        write_reg(ssnap_pkg::REG_END_B_Z, bz);
        write_reg(ssnap_pkg::REG_SNAP_RADIUS, r);
        write_reg(REG_UNUSED, $urandom);
        repeat (4) @(posedge i_clk);
    endtask

    // random point near the segment, sometimes anywhere
    task automatic send_near(int spread);
        logic signed [63:0] t, p [3];
        if ($urandom_range(0, 9) == 0) begin
            send_query($urandom, $urandom, $urandom);
            return;
        end
        t = $signed(64'($urandom_range(0, 1400))) - 64'sd200;
        for (int i = 0; i < 3; i++)
            p[i] = 64'(seg_a[i]) + ((64'(seg_b[i]) - 64'(seg_a[i])) * t) / 1000
                   + $signed(64'($urandom_range(0, 2 * spread))) - spread;
        for (int i = 0; i < 3; i++)
            if (p[i] > 64'sh7fffffff) p[i] = 64'sh7fffffff;
            else if (p[i] < -64'sh80000000) p[i] = -64'sh80000000;
        send_query(p[0][31:0], p[1][31:0], p[2][31:0]);
    endtask

    task automatic test_directed();
        set_segment(32'h0, 32'h0, 32'h0, 32'h000a0000, 32'h0, 32'h0, 31'h00010000);
        send_query(32'h00050000, 32'h00008000, 32'h0);
        send_query(32'hffff8000, 32'h0, 32'h0);
        send_query(32'h000a8000, 32'h0, 32'h0);
        send_query(32'h0, 32'h0, 32'h0);
        send_query(32'h000a0000, 32'h0, 32'h0);
        send_query(32'h00050000, 32'h00010000, 32'h0);
        send_query(32'h00050000, 32'h0000ffff, 32'h0);
        send_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_query(32'h80000000, 32'h80000000, 32'h80000000);
        drain();
        set_segment(32'h80000000, 32'h80000000, 32'h80000000,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
        send_query(32'h0, 32'h0, 32'h0);
        send_query(32'h7fffffff, 32'h80000000, 32'h12345678);
        send_query(32'h80000000, 32'h7fffffff, 32'hffffffff);
        send_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_query(32'h00000003, 32'hfffffffd, 32'h55555555);
        drain();
        set_segment(32'h00030000, 32'hfffd0000, 32'h1, 32'h00030000, 32'hfffd0000, 32'h1,
                    31'h7fffffff);
        send_query(32'h00030000, 32'hfffd0000, 32'h1);
        send_query(32'h0, 32'h0, 32'h0);
        drain();
        set_segment(32'h1, 32'h2, 32'h3, 32'h7, 32'hfffffff0, 32'h9, 31'h0);
        send_query(32'h1, 32'h2, 32'h3);
        send_query(32'h4, 32'h0, 32'h5);
        drain();
    endtask

    task automatic test_random(int n, int spread);
        for (int i = 0; i < n; i++) send_near(spread);
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 120; i++) send_near(1000);
        join
        drain();
    endtask

    initial begin
        for (int i = 0; i < 3; i++) begin
            seg_a[i] = 0;
            seg_b[i] = 0;
        end
        radius = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        for (int k = 0; k < 6; k++) begin
            set_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
            test_random(60, 1 << $urandom_range(0, 30));
            set_segment($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                        $urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                        $urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                        $urandom_range(0, 3000));
            test_random(60, 2000);
        end
        test_backpressure();
        if (mismatch_cnt == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

[segment_snap_3d_unit.f]
src/ssnap_pkg.sv
src/ssnap_div.sv
src/segment_snap_3d_unit.sv
test/tb.sv
